@@ design/swm_pkg.sv @@
// swm_pkg: shared sizes, types and link struct for the running median filter
// used by swm_cell, sliding_window_median and swm_checker; no dependencies
package swm_pkg;

	// window capacity and field widths
	localparam int WINDOW_MAX = 16;
	localparam int SAMPLE_W   = 16;
	localparam int LEN_W      = 5;
	localparam int AGE_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int CNT_W      = $clog2(WINDOW_MAX + 1);

	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(16);

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic [AGE_W-1:0]           age_t;
	typedef logic [CNT_W-1:0]           cnt_t;
	typedef logic [LEN_W-1:0]           len_t;

	// what one cell hands to its upper neighbor: its slot of the window with the
	// oldest entry taken out, and whether that entry stays at or below the new sample
	typedef struct packed {
		sample_t val;
		age_t    age;
		logic    le;
	} swm_link_t;

endpackage

@@ design/sliding_window_median.sv @@
// sliding_window_median: running median over the last window_length samples
// output: the median of an accepted request is registered on the output in the cycle after acceptance
// throughput: one request per cycle while in_stall is low; the cell row updates on each accepted request
// reset: length 16, window zeros; after reset in_stall is high while the
// cell row is cleared; a window_length write also clears the row in that cycle
// depends on swm_pkg and swm_cell
module sliding_window_median import swm_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    window_length_we,
	input  len_t    window_length,
	input  logic    in_valid,
	output logic    in_stall,
	input  sample_t sample,
	output logic    out_valid,
	input  logic    out_stall,
	output sample_t median
);

	len_t      len_q;
	logic      init_q;
	logic      out_valid_q;
	sample_t   median_q;
	cnt_t      n;
	cnt_t      mid;
	logic      accept;
	logic      clear;

	sample_t   vals     [WINDOW_MAX];
	age_t      ages     [WINDOW_MAX];
	logic      shifts   [WINDOW_MAX];
	swm_link_t links    [WINDOW_MAX];
	sample_t   nxt_vals [WINDOW_MAX];

	assign in_stall  = init_q | (out_valid_q & out_stall);
	assign accept    = in_valid & ~in_stall;
	assign clear     = init_q | window_length_we;
	assign out_valid = out_valid_q;
	assign median    = median_q;

	// effective length, clamped to 1..WINDOW_MAX
	always_comb begin
		if (len_q == '0) begin
			n = cnt_t'(1);
		end else if (int'(len_q) > WINDOW_MAX) begin
			n = cnt_t'(WINDOW_MAX);
		end else begin
			n = cnt_t'(len_q);
		end
		mid = n >> 1;
	end

	// length register and post-reset clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= LEN_RESET;
			init_q <= 1'b1;
		end else begin
			init_q <= 1'b0;
			if (window_length_we) begin
				len_q <= window_length;
			end
		end
	end

	// row of cells, lowest value in cell 0
	for (genvar g = 0; g < WINDOW_MAX; g++) begin : g_cell
		sample_t   up_val;
		age_t      up_age;
		logic      prev_shift;
		swm_link_t prev_r;

		if (g == 0) begin : g_lo
			assign prev_shift = 1'b0;
			assign prev_r     = '{val: '0, age: '0, le: 1'b1};
		end else begin : g_mid
			assign prev_shift = shifts[g-1];
			assign prev_r     = links[g-1];
		end

		if (g == WINDOW_MAX - 1) begin : g_hi
			assign up_val = '0;
			assign up_age = '0;
		end else begin : g_up
			assign up_val = vals[g+1];
			assign up_age = ages[g+1];
		end

		swm_cell u_cell (
			.clk        (clk),
			.load       (accept),
			.clear      (clear),
			.idx        (age_t'(g)),
			.len        (n),
			.x          (sample),
			.up_val     (up_val),
			.up_age     (up_age),
			.prev_shift (prev_shift),
			.prev_r     (prev_r),
			.val        (vals[g]),
			.age        (ages[g]),
			.shift      (shifts[g]),
			.r          (links[g]),
			.nxt_val    (nxt_vals[g])
		);
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload: middle slot of the updated row
	always_ff @(posedge clk) begin
		if (accept) begin
			median_q <= nxt_vals[mid[AGE_W-1:0]];
		end
	end

endmodule

@@ design/swm_cell.sv @@
// swm_cell: one slot of the sorted window, value plus age since insertion
// depends on swm_pkg; a row of these forms the insertion chain in the top level
module swm_cell import swm_pkg::*; (
	input  logic      clk,
	input  logic      load,
	input  logic      clear,
	input  age_t      idx,
	input  cnt_t      len,
	input  sample_t   x,
	input  sample_t   up_val,
	input  age_t      up_age,
	input  logic      prev_shift,
	input  swm_link_t prev_r,
	output sample_t   val,
	output age_t      age,
	output logic      shift,
	output swm_link_t r,
	output sample_t   nxt_val
);

	sample_t val_q;
	age_t    age_q;
	age_t    nxt_age;
	sample_t rv;
	age_t    ra;
	logic    active;
	logic    ok;
	logic    del;
	logic    rle;

	assign val = val_q;
	assign age = age_q;

	// oldest entry leaves; slots above it slide down by one
	always_comb begin
		active = cnt_t'(idx) < len;
		ok     = (cnt_t'(idx) + cnt_t'(1)) < len;
		del    = active && ((cnt_t'(age_q) + cnt_t'(1)) == len);
		shift  = prev_shift | del;
		rv     = shift ? up_val : val_q;
		ra     = shift ? up_age : age_q;
		rle    = ok && (rv <= x);
		r.val  = rv;
		r.age  = ra;
		r.le   = rle;
	end

	// keep own entry, take the new sample, or take the neighbor below
	always_comb begin
		if (rle) begin
			nxt_val = rv;
			nxt_age = ra + age_t'(1);
		end else if (prev_r.le) begin
			nxt_val = x;
			nxt_age = '0;
		end else begin
			nxt_val = prev_r.val;
			nxt_age = prev_r.age + age_t'(1);
		end
	end

	// slot storage; clear gives every slot a distinct age
	always_ff @(posedge clk) begin
		if (clear) begin
			val_q <= '0;
			age_q <= idx;
		end else if (load && active) begin
			val_q <= nxt_val;
			age_q <= nxt_age;
		end
	end

endmodule

@@ design/swm_checker.sv @@
// swm_checker: port-level checks for sliding_window_median, bound to the top level
// depends on swm_pkg
module swm_checker import swm_pkg::*; (
	input logic    clk,
	input logic    arst_n,
	input logic    window_length_we,
	input len_t    window_length,
	input logic    in_valid,
	input logic    in_stall,
	input sample_t sample,
	input logic    out_valid,
	input logic    out_stall,
	input sample_t median
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(median)))
		else $error("stalled median changed or dropped");

	// every accepted request gives a result next cycle
	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> out_valid)
		else $error("accepted request produced no result");

	// a result being taken never blocks the input
	a_no_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall) |-> !in_stall)
		else $error("input stalled while output drains");

	// with a window of one the median is the sample itself
	a_len_one: assert property (@(posedge clk) disable iff (!arst_n)
		(window_length_we && (window_length == LEN_W'(1) || window_length == LEN_W'(0)))
		##1 (in_valid && !in_stall && !window_length_we)
		|=> (out_valid && median == $past(sample)))
		else $error("single-sample window median mismatch");

endmodule

bind sliding_window_median swm_checker u_swm_checker (.*);
